FILE: hdl/gdr_pkg.sv
// ----------------------------------------------------------------------------
// gdr_pkg
// Shared types, constants and helpers for the gated delta rule state update.
// ----------------------------------------------------------------------------
`default_nettype none

package gdr_pkg;

  localparam int SLOTS_DEF     = 16;
  localparam int KEY_MAX_DEF   = 64;
  localparam int VALUE_MAX_DEF = 64;

  localparam int LEN_W  = 7;
  localparam int IDX_W  = 6;
  localparam int SLOT_W = 6;
  localparam int GATE_W = 25;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              clear;
    logic [GATE_W-1:0] gate;
    logic [15:0]       beta;
  } cmd_t;

  typedef struct packed {
    logic               key_we;
    logic               val_we;
    logic [IDX_W-1:0]   idx;
    logic signed [15:0] key;
    logic signed [15:0] query;
    logic signed [15:0] value;
  } store_wr_t;

  // exp(-2^(b-12)) in Q0.24
  function automatic logic [23:0] exp_neg(input logic [3:0] b);
    logic [23:0] r;
    case (b)
      4'd0:    r = 24'd16773120;
      4'd1:    r = 24'd16769026;
      4'd2:    r = 24'd16760840;
      4'd3:    r = 24'd16744480;
      4'd4:    r = 24'd16711808;
      4'd5:    r = 24'd16646655;
      4'd6:    r = 24'd16517109;
      4'd7:    r = 24'd16261035;
      4'd8:    r = 24'd15760736;
      4'd9:    r = 24'd14805841;
      4'd10:   r = 24'd13066109;
      4'd11:   r = 24'd10175896;
      4'd12:   r = 24'd6171993;
      4'd13:   r = 24'd2270549;
      4'd14:   r = 24'd307285;
      default: r = 24'd5628;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    logic signed [31:0] r;
    if (v > $signed(72'h0000_0000_007F_FFFF_FF)) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < $signed({40'hFF_FFFF_FFFF, 32'h8000_0000})) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/gdr_front.sv
// ----------------------------------------------------------------------------
// gdr_front
// Accepts element items, fills the vector stores, captures the step
// parameters and forms the decay gate one exponent bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gdr_front #(
  parameter int SLOTS = gdr_pkg::SLOTS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [3:0]                  state_slot,
  input  wire logic                        clear_state,
  input  wire logic signed [15:0]          key_elem,
  input  wire logic signed [15:0]          query_elem,
  input  wire logic signed [15:0]          value_elem,
  input  wire logic signed [15:0]          log_decay,
  input  wire logic [15:0]                 beta,
  input  wire logic                        last_in,
  input  wire logic [gdr_pkg::LEN_W-1:0]   kl,
  input  wire logic [gdr_pkg::LEN_W-1:0]   vl,
  input  wire logic                        hold,
  input  wire logic                        q_full,
  output logic                             push,
  output gdr_pkg::cmd_t                    cmd,
  output gdr_pkg::store_wr_t               wr
);

  logic [gdr_pkg::LEN_W-1:0]  cnt;
  logic                       pend;
  logic                       gbusy;
  logic [3:0]                 gbit;
  logic [15:0]                m;
  logic [gdr_pkg::GATE_W-1:0] gate;
  logic [gdr_pkg::SLOT_W-1:0] slot;
  logic                       clr;
  logic [15:0]                beta_q;
  logic                       acc;
  logic [48:0]                gprod;
  logic [gdr_pkg::GATE_W-1:0] gate_rnd;
  logic [15:0]                m_in;

  function automatic logic [gdr_pkg::SLOT_W-1:0] slot_wrap(input logic [3:0] s);
    logic [gdr_pkg::SLOT_W-1:0] r;
    r = '0;
    for (int v = 0; v < 16; v++) begin
      if (s == 4'(v)) begin
        r = gdr_pkg::SLOT_W'(v % SLOTS);
      end
    end
    return r;
  endfunction

  assign in_ready = !pend && !hold;
  assign acc      = in_valid && in_ready;
  assign push     = pend && !gbusy && !q_full;
  assign gprod    = 49'(gate) * 49'(gdr_pkg::exp_neg(gbit));
  assign gate_rnd = gdr_pkg::GATE_W'((gprod + 49'd8388608) >> 24);
  assign m_in     = log_decay[15] ? 16'(17'sd0 - 17'(log_decay)) : 16'd0;

  assign cmd = '{slot: slot, clear: clr, gate: gate, beta: beta_q};

  always_comb begin
    wr.key_we = acc && (cnt < kl);
    wr.val_we = acc && (cnt < vl);
    wr.idx    = gdr_pkg::IDX_W'(cnt);
    wr.key    = key_elem;
    wr.query  = query_elem;
    wr.value  = value_elem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      pend  <= 1'b0;
      gbusy <= 1'b0;
      gbit  <= '0;
      m     <= '0;
      gate  <= '0;
      slot  <= '0;
      clr   <= 1'b0;
      beta_q <= '0;
    end else begin
      if (gbusy) begin
        if (m[gbit]) begin
          gate <= gate_rnd;
        end
        gbit <= gbit + 4'd1;
        if (gbit == 4'd15) begin
          gbusy <= 1'b0;
        end
      end
      if (push) begin
        pend <= 1'b0;
      end
      if (acc) begin
        if (cnt == '0) begin
          slot   <= slot_wrap(state_slot);
          clr    <= clear_state;
          beta_q <= beta;
          m      <= m_in;
          gate   <= gdr_pkg::GATE_W'(25'h100_0000);
          gbit   <= '0;
          gbusy  <= 1'b1;
        end
        if (last_in) begin
          cnt  <= '0;
          pend <= 1'b1;
        end else if (cnt < 7'd64) begin
          cnt <= cnt + 7'd1;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/gdr_cmd_queue.sv
// ----------------------------------------------------------------------------
// gdr_cmd_queue
// Two-entry queue of step commands between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module gdr_cmd_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  gdr_pkg::cmd_t      din,
  output logic               full,
  input  wire logic          pop,
  output gdr_pkg::cmd_t      dout,
  output logic               valid
);

  gdr_pkg::cmd_t mem [2];
  logic          wp;
  logic          rp;
  logic [1:0]    count;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign dout  = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= '0;
    end else begin
      if (push && !full) begin
        mem[wp] <= din;
        wp      <= ~wp;
      end
      if (pop && valid) begin
        rp <= ~rp;
      end
      count <= count + 2'((push && !full) ? 1 : 0) - 2'((pop && valid) ? 1 : 0);
    end
  end

endmodule

`default_nettype wire

FILE: hdl/gdr_back.sv
// ----------------------------------------------------------------------------
// gdr_back
// Row-wide sequencer over the head matrix memory: clear, decay with key
// dot products, delta, rank-one update with query dot products, emission.
// ----------------------------------------------------------------------------
`default_nettype none

module gdr_back #(
  parameter int SLOTS     = gdr_pkg::SLOTS_DEF,
  parameter int KEY_MAX   = gdr_pkg::KEY_MAX_DEF,
  parameter int VALUE_MAX = gdr_pkg::VALUE_MAX_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [gdr_pkg::LEN_W-1:0] kl,
  input  wire logic [gdr_pkg::LEN_W-1:0] vl,
  input  gdr_pkg::store_wr_t             wr,
  input  wire logic                      q_valid,
  input  gdr_pkg::cmd_t                  q_cmd,
  output logic                           q_pop,
  output logic                           busy,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic signed [31:0]             out_elem,
  output logic [5:0]                     out_index,
  output logic                           last_out
);

  localparam int KW   = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
  localparam int VW   = (VALUE_MAX > 1) ? $clog2(VALUE_MAX) : 1;
  localparam int ROWS = SLOTS * KEY_MAX;
  localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int RW   = VALUE_MAX * 32;

  typedef enum logic [7:0] {
    ST_INIT   = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_CLEAR  = 8'b0000_0100,
    ST_DECAY  = 8'b0000_1000,
    ST_DELTA  = 8'b0001_0000,
    ST_UPDATE = 8'b0010_0000,
    ST_FINAL  = 8'b0100_0000,
    ST_EMIT   = 8'b1000_0000
  } state_t;

  state_t             state;
  logic [2:0]         ph;
  logic [KW-1:0]      row;
  logic [AW-1:0]      irow;
  logic [VW-1:0]      ej;
  gdr_pkg::cmd_t      cmd;

  logic [RW-1:0]      mem [ROWS];
  logic [RW-1:0]      rd_data;
  logic [RW-1:0]      s_new;
  logic signed [15:0] kmem [KEY_MAX];
  logic signed [15:0] qmem [KEY_MAX];
  logic signed [15:0] k_rd;
  logic signed [15:0] q_rd;
  logic signed [15:0] vreg   [VALUE_MAX];
  logic signed [57:0] p_dec  [VALUE_MAX];
  logic signed [47:0] p_inc  [VALUE_MAX];
  logic signed [47:0] p_acc  [VALUE_MAX];
  logic signed [63:0] acc    [VALUE_MAX];
  logic signed [53:0] diff   [VALUE_MAX];
  logic signed [70:0] p_beta [VALUE_MAX];
  logic signed [31:0] delta  [VALUE_MAX];
  logic signed [31:0] outv   [VALUE_MAX];

  logic               mem_we;
  logic               mem_re;
  logic [AW-1:0]      mem_addr;
  logic [RW-1:0]      mem_wd;
  logic [RW-1:0]      dec_wd;
  logic [RW-1:0]      upd_wd;
  logic [AW-1:0]      row_addr;
  logic               row_last;
  logic               ej_last;
  logic               emit_load;

  assign row_addr  = AW'(13'(cmd.slot) * 13'(KEY_MAX) + 13'(row));
  assign row_last  = (gdr_pkg::LEN_W'(row) == kl - 7'd1);
  assign ej_last   = (gdr_pkg::LEN_W'(ej) == vl - 7'd1);
  assign emit_load = (state == ST_EMIT) && (!out_valid || out_ready);
  assign q_pop     = (state == ST_IDLE) && q_valid;
  assign busy      = (state != ST_IDLE);

  always_comb begin
    for (int j = 0; j < VALUE_MAX; j++) begin
      if (gdr_pkg::LEN_W'(j) < vl) begin
        dec_wd[j*32 +: 32] = gdr_pkg::sat32(72'((p_dec[j] + 58'sd8388608) >>> 24));
        upd_wd[j*32 +: 32] = gdr_pkg::sat32(72'($signed(rd_data[j*32 +: 32]))
                                            + 72'((p_inc[j] + 48'sd2048) >>> 12));
      end else begin
        dec_wd[j*32 +: 32] = rd_data[j*32 +: 32];
        upd_wd[j*32 +: 32] = rd_data[j*32 +: 32];
      end
    end
  end

  always_comb begin
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = row_addr;
    mem_wd   = '0;
    case (state)
      ST_INIT: begin
        mem_we   = 1'b1;
        mem_addr = irow;
      end
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_DECAY: begin
        mem_re = (ph == 3'd0);
        mem_we = (ph == 3'd2);
        mem_wd = dec_wd;
      end
      ST_UPDATE: begin
        mem_re = (ph == 3'd0);
        mem_we = (ph == 3'd2);
        mem_wd = upd_wd;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      ph        <= '0;
      row       <= '0;
      irow      <= '0;
      ej        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !emit_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_INIT: begin
          irow <= irow + AW'(1);
          if (irow == AW'(ROWS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_valid) begin
            cmd   <= q_cmd;
            row   <= '0;
            ph    <= '0;
            state <= q_cmd.clear ? ST_CLEAR : ST_DECAY;
          end
        end
        ST_CLEAR: begin
          if (row == KW'(KEY_MAX - 1)) begin
            row   <= '0;
            state <= ST_DECAY;
          end else begin
            row <= row + KW'(1);
          end
        end
        ST_DECAY: begin
          if (ph == 3'd4) begin
            ph <= '0;
            if (row_last) begin
              row   <= '0;
              state <= ST_DELTA;
            end else begin
              row <= row + KW'(1);
            end
          end else begin
            ph <= ph + 3'd1;
          end
        end
        ST_DELTA: begin
          if (ph == 3'd2) begin
            ph    <= '0;
            state <= ST_UPDATE;
          end else begin
            ph <= ph + 3'd1;
          end
        end
        ST_UPDATE: begin
          if (ph == 3'd4) begin
            ph <= '0;
            if (row_last) begin
              row   <= '0;
              state <= ST_FINAL;
            end else begin
              row <= row + KW'(1);
            end
          end else begin
            ph <= ph + 3'd1;
          end
        end
        ST_FINAL: begin
          ej    <= '0;
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_load) begin
            out_valid <= 1'b1;
            out_elem  <= outv[ej];
            out_index <= 6'(ej);
            last_out  <= ej_last;
            if (ej_last) begin
              state <= ST_IDLE;
            end else begin
              ej <= ej + VW'(1);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wd;
    end
    if (mem_re) begin
      rd_data <= mem[mem_addr];
      k_rd    <= kmem[row];
      q_rd    <= qmem[row];
    end
    if (wr.key_we) begin
      kmem[wr.idx[KW-1:0]] <= wr.key;
      qmem[wr.idx[KW-1:0]] <= wr.query;
    end
    for (int j = 0; j < VALUE_MAX; j++) begin
      if (wr.val_we && (wr.idx == gdr_pkg::IDX_W'(j))) begin
        vreg[j] <= wr.value;
      end
    end
    if (mem_we) begin
      s_new <= mem_wd;
    end
    for (int j = 0; j < VALUE_MAX; j++) begin
      case (state)
        ST_IDLE: begin
          acc[j] <= '0;
        end
        ST_DECAY, ST_UPDATE: begin
          if (ph == 3'd1) begin
            p_dec[j] <= $signed(rd_data[j*32 +: 32]) * $signed({1'b0, cmd.gate});
            p_inc[j] <= k_rd * delta[j];
          end
          if (ph == 3'd3) begin
            p_acc[j] <= $signed(s_new[j*32 +: 32]) * ((state == ST_DECAY) ? k_rd : q_rd);
          end
          if (ph == 3'd4) begin
            acc[j] <= acc[j] + 64'(p_acc[j]);
          end
        end
        ST_DELTA: begin
          if (ph == 3'd0) begin
            diff[j] <= (54'(vreg[j]) <<< 4) - 54'((acc[j] + 64'sd2048) >>> 12);
          end
          if (ph == 3'd1) begin
            p_beta[j] <= diff[j] * $signed({1'b0, cmd.beta});
          end
          if (ph == 3'd2) begin
            delta[j] <= gdr_pkg::sat32(72'((p_beta[j] + 71'sd32768) >>> 16));
            acc[j]   <= '0;
          end
        end
        ST_FINAL: begin
          outv[j] <= gdr_pkg::sat32(72'((acc[j] + 64'sd2048) >>> 12));
        end
        default: begin
          acc[j] <= acc[j];
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/gated_delta_rule_state_update.sv
// ----------------------------------------------------------------------------
// gated_delta_rule_state_update
// One gated delta rule step per run of element items, over a slot matrix.
// ----------------------------------------------------------------------------
// Element items are taken one per cycle while in_ready is high; the first
// item of a step starts the gate unit. Once the last item is in and the gate
// is formed, the step is queued and the row-wide back end runs over the slot
// matrix memory, one row read-modify-write at a time: clearing of KEY_MAX rows
// if requested, decay over key_len rows, delta, update over key_len rows, a
// rounding step, then value_len results at one per cycle while out_ready is
// high. New items are held off while the back end runs. After reset a clearing
// pass over SLOTS*KEY_MAX rows zeroes the matrix memory before any step runs.
`default_nettype none

module gated_delta_rule_state_update #(
  parameter int SLOTS     = gdr_pkg::SLOTS_DEF,
  parameter int KEY_MAX   = gdr_pkg::KEY_MAX_DEF,
  parameter int VALUE_MAX = gdr_pkg::VALUE_MAX_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [3:0]         state_slot,
  input  wire logic               clear_state,
  input  wire logic signed [15:0] key_elem,
  input  wire logic signed [15:0] query_elem,
  input  wire logic signed [15:0] value_elem,
  input  wire logic signed [15:0] log_decay,
  input  wire logic [15:0]        beta,
  input  wire logic               last_in,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_elem,
  output logic [5:0]              out_index,
  output logic                    last_out
);

  logic [gdr_pkg::LEN_W-1:0] key_len;
  logic [gdr_pkg::LEN_W-1:0] value_len;
  logic [gdr_pkg::LEN_W-1:0] kl_eff;
  logic [gdr_pkg::LEN_W-1:0] vl_eff;
  logic                      busy;
  logic                      q_full;
  logic                      q_valid;
  logic                      q_pop;
  logic                      push;
  gdr_pkg::cmd_t             cmd_in;
  gdr_pkg::cmd_t             cmd_out;
  gdr_pkg::store_wr_t        wr;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? {25'd0, value_len} : {25'd0, key_len};

  always_ff @(posedge clk) begin
    if (rst) begin
      key_len   <= 7'd64;
      value_len <= 7'd64;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2]) begin
        value_len <= pwdata[6:0];
      end else begin
        key_len <= pwdata[6:0];
      end
    end
  end

  assign kl_eff = (key_len == '0) ? 7'd1 :
                  (key_len > 7'(KEY_MAX)) ? 7'(KEY_MAX) : key_len;
  assign vl_eff = (value_len == '0) ? 7'd1 :
                  (value_len > 7'(VALUE_MAX)) ? 7'(VALUE_MAX) : value_len;

  gdr_front #(.SLOTS(SLOTS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .state_slot (state_slot),
    .clear_state(clear_state),
    .key_elem   (key_elem),
    .query_elem (query_elem),
    .value_elem (value_elem),
    .log_decay  (log_decay),
    .beta       (beta),
    .last_in    (last_in),
    .kl         (kl_eff),
    .vl         (vl_eff),
    .hold       (busy || q_valid),
    .q_full     (q_full),
    .push       (push),
    .cmd        (cmd_in),
    .wr         (wr)
  );

  gdr_cmd_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (cmd_in),
    .full (q_full),
    .pop  (q_pop),
    .dout (cmd_out),
    .valid(q_valid)
  );

  gdr_back #(
    .SLOTS    (SLOTS),
    .KEY_MAX  (KEY_MAX),
    .VALUE_MAX(VALUE_MAX)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .kl       (kl_eff),
    .vl       (vl_eff),
    .wr       (wr),
    .q_valid  (q_valid),
    .q_cmd    (cmd_out),
    .q_pop    (q_pop),
    .busy     (busy),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_elem (out_elem),
    .out_index(out_index),
    .last_out (last_out)
  );

`ifndef SYNTH
  a_busy_holds_input: assert property (@(posedge clk) disable iff (rst)
    busy |-> !in_ready) else $error("item accepted while back end busy");

  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, out_index} < vl_eff)) else $error("out_index past value_len");

  a_last_at_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_out) |-> ({1'b0, out_index} == vl_eff - 7'd1))
    else $error("last_out not on final element");
`endif

endmodule

`default_nettype wire

FILE: tb/gated_delta_rule_state_update_tb.sv
// ----------------------------------------------------------------------------
// gated_delta_rule_state_update_tb
// Drives element items for gated delta rule steps over random slots and head
// sizes. A local fixed-point model of the slot matrices predicts each output
// element, and every output item is checked field by field in arrival order.
// The run covers directed corner steps, random steps, output back-pressure
// and pauses at the input.
// ----------------------------------------------------------------------------
`default_nettype none

module gated_delta_rule_state_update_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 16;
  localparam int KMAX = 64;
  localparam int VMAX = 64;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam logic [2:0] ADDR_KEY_LEN = 3'd0;
  localparam logic [2:0] ADDR_VALUE_LEN = 3'd4;

  typedef struct {
    logic [3:0] slot;
    logic clear;
    logic signed [15:0] key;
    logic signed [15:0] query;
    logic signed [15:0] value;
    logic signed [15:0] decay;
    logic [15:0] beta;
    logic last;
  } elem_item_t;

  typedef struct {
    logic signed [31:0] elem;
    logic [5:0] index;
    logic last;
  } out_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [3:0] state_slot = '0;
  logic clear_state = 1'b0;
  logic signed [15:0] key_elem = '0, query_elem = '0, value_elem = '0, log_decay = '0;
  logic [15:0] beta = '0;
  logic last_in = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_elem;
  logic [5:0] out_index;
  logic last_out;

  always #1 clk = ~clk;

  gated_delta_rule_state_update DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .state_slot(state_slot), .clear_state(clear_state),
    .key_elem(key_elem), .query_elem(query_elem), .value_elem(value_elem),
    .log_decay(log_decay), .beta(beta), .last_in(last_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_elem(out_elem), .out_index(out_index), .last_out(last_out)
  );

  // model state
  int mat [NSLOT*KMAX*VMAX];
  int key_mem [KMAX];
  int query_mem [KMAX];
  int value_mem [VMAX];
  int delta_mem [VMAX];
  int unsigned elem_count;
  longint gate_q24;
  int unsigned step_beta;
  int unsigned step_slot;
  bit step_clear;
  logic [6:0] key_len_reg = 7'd64;
  logic [6:0] value_len_reg = 7'd64;

  out_item_t expected_outputs[$];
  bit failed = 1'b0;
  bit no_gaps = 1'b0;
  int hold_off = 0;
  int out_stall = 0;
  int idle_cycles = 0;
  int random_items = 0;

  function automatic longint rshr(longint v, int sh);
    return (v + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic int sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  function automatic int unsigned eff_len(logic [6:0] r, int unsigned lim);
    if (r == 0) return 1;
    return (r > lim) ? lim : r;
  endfunction

  function automatic longint decay_gate(logic signed [15:0] g);
    longint unsigned tbl [16] = '{16773120, 16769026, 16760840, 16744480,
                                  16711808, 16646655, 16517109, 16261035,
                                  15760736, 14805841, 13066109, 10175896,
                                  6171993, 2270549, 307285, 5628};
    int unsigned m;
    longint unsigned acc;
    m = (g >= 0) ? 0 : -int'(g);
    acc = 64'd1 << 24;
    for (int b = 0; b < 16; b++)
      if (m[b]) acc = (acc * tbl[b] + (64'd1 << 23)) >> 24;
    return longint'(acc);
  endfunction

  function automatic void predict_item(elem_item_t it);
    int unsigned kl, vl, base;
    longint acc, diff;
    kl = eff_len(key_len_reg, KMAX);
    vl = eff_len(value_len_reg, VMAX);
    if (elem_count == 0) begin
      step_slot = it.slot % NSLOT;
      step_clear = it.clear;
      gate_q24 = decay_gate(it.decay);
      step_beta = it.beta;
    end
    if (elem_count < kl) begin
      key_mem[elem_count] = it.key;
      query_mem[elem_count] = it.query;
    end
    if (elem_count < vl) value_mem[elem_count] = it.value;
    if (!it.last) begin
      if (elem_count < 64) elem_count++;
      return;
    end
    elem_count = 0;
    base = step_slot * KMAX * VMAX;
    if (step_clear)
      for (int n = 0; n < KMAX * VMAX; n++) mat[base + n] = 0;
    for (int i = 0; i < kl; i++)
      for (int j = 0; j < vl; j++)
        mat[base + i*VMAX + j] = sat32(rshr(longint'(mat[base + i*VMAX + j]) * gate_q24, 24));
    for (int j = 0; j < vl; j++) begin
      acc = 0;
      for (int i = 0; i < kl; i++)
        acc += longint'(mat[base + i*VMAX + j]) * key_mem[i];
      diff = longint'(value_mem[j]) * 16 - rshr(acc, 12);
      delta_mem[j] = sat32(rshr(diff * longint'(step_beta), 16));
    end
    for (int i = 0; i < kl; i++)
      for (int j = 0; j < vl; j++)
        mat[base + i*VMAX + j] = sat32(longint'(mat[base + i*VMAX + j]) +
                                       rshr(longint'(key_mem[i]) * delta_mem[j], 12));
    for (int j = 0; j < vl; j++) begin
      out_item_t o;
      acc = 0;
      for (int i = 0; i < kl; i++)
        acc += longint'(mat[base + i*VMAX + j]) * query_mem[i];
      o.elem = sat32(rshr(acc, 12));
      o.index = j[5:0];
      o.last = (j + 1 == vl);
      expected_outputs.push_back(o);
    end
  endfunction

  // ---------------- drivers ----------------
  task automatic send_item(elem_item_t it);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    state_slot = it.slot; clear_state = it.clear; key_elem = it.key;
    query_elem = it.query; value_elem = it.value; log_decay = it.decay;
    beta = it.beta; last_in = it.last;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_item(it);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    in_valid = 1'b0;
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0; paddr = addr; pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_KEY_LEN) key_len_reg = data[6:0];
    else value_len_reg = data[6:0];
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic drain;
    in_valid = 1'b0;
    while (expected_outputs.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_lengths(logic [6:0] kl, logic [6:0] vl);
    drain();
    write_reg(ADDR_KEY_LEN, {25'd0, kl});
    write_reg(ADDR_VALUE_LEN, {25'd0, vl});
  endtask

  function automatic logic signed [15:0] rand_decay();
    case ($urandom_range(0, 7))
      0: return 16'($urandom_range(0, 32767));
      1, 2: return 16'(-$urandom_range(0, 32768));
      default: return 16'(-$urandom_range(0, 2048));
    endcase
  endfunction

  task automatic run_step(logic [3:0] slot, bit clr, int n, bit count_it);
    elem_item_t it;
    logic signed [15:0] dg;
    logic [15:0] bt;
    dg = rand_decay();
    bt = 16'($urandom);
    for (int e = 0; e < n; e++) begin
      it.slot = (e == 0) ? slot : 4'($urandom);
      it.clear = (e == 0) ? clr : 1'($urandom);
      it.key = 16'($urandom); it.query = 16'($urandom); it.value = 16'($urandom);
      it.decay = (e == 0) ? dg : 16'($urandom);
      it.beta = (e == 0) ? bt : 16'($urandom);
      it.last = (e == n - 1);
      send_item(it);
      if (count_it) random_items++;
    end
  endtask

  // ---------------- tests ----------------
  task automatic test_full_head;
    set_lengths(7'd64, 7'd64);
    run_step(4'd3, 1'b1, 64, 1'b0);
    run_step(4'd3, 1'b0, 64, 1'b0);
  endtask

  task automatic test_corners;
    elem_item_t it;
    set_lengths(7'd2, 7'd2);
    it = '{4'd15, 1'b1, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh0000, 16'hFFFF, 1'b0};
    send_item(it);
    it = '{4'd0, 1'b0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'h0000, 1'b1};
    send_item(it);
    it = '{4'd15, 1'b0, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'hFFFF, 1'b1};
    send_item(it);
    it = '{4'd15, 1'b0, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'h0000, 1'b1};
    send_item(it);
    for (int e = 0; e < 4; e++) begin
      it = '{4'd15, 1'b0, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh0000, 16'hFFFF, e == 3};
      send_item(it);
    end
    set_lengths(7'd0, 7'd127);
    run_step(4'd7, 1'b1, 2, 1'b0);
    set_lengths(7'd127, 7'd0);
    run_step(4'd7, 1'b0, 3, 1'b0);
    set_lengths(7'd5, 7'd3);
    run_step(4'd9, 1'b1, 6, 1'b0);
    run_step(4'd9, 1'b0, 1, 1'b0);
  endtask

  task automatic test_random_steps(int target);
    int kl, vl, n;
    while (random_items < target) begin
      case ($urandom_range(0, 9))
        0: begin kl = 64; vl = $urandom_range(1, 64); end
        1: begin kl = $urandom_range(0, 127); vl = $urandom_range(0, 127); end
        default: begin kl = $urandom_range(1, 8); vl = $urandom_range(1, 8); end
      endcase
      set_lengths(7'(kl), 7'(vl));
      no_gaps = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(2, 6)) begin
        case ($urandom_range(0, 15))
          0: n = $urandom_range(65, 70);
          1: n = 1;
          default: n = $urandom_range(1, eff_len(7'(kl), KMAX) + 2);
        endcase
        if (n > 20 && $urandom_range(0, 3) != 0) n = $urandom_range(1, 8);
        run_step(4'($urandom), $urandom_range(0, 5) == 0, n, 1'b1);
      end
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_output_hold_off;
    set_lengths(7'd4, 7'd6);
    no_gaps = 1'b1;
    hold_off = 400;
    repeat (4) run_step(4'($urandom), 1'b0, 4, 1'b1);
    no_gaps = 1'b0;
  endtask

  task automatic test_input_pause;
    set_lengths(7'd3, 7'd5);
    repeat (3) begin
      run_step(4'($urandom), 1'b0, 3, 1'b1);
      drain();
    end
  endtask

  // ---------------- receiver and checker ----------------
  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else if (out_stall > 0) begin
      out_ready <= 1'b0;
      out_stall <= out_stall - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      out_stall <= no_gaps ? 0 : $urandom_range(0, 14);
      if (expected_outputs.size() == 0) begin
        $display("%0t: unexpected output elem=%0d index=%0d last=%0b",
                 $time, out_elem, out_index, last_out);
        failed = 1'b1;
      end else begin
        out_item_t e;
        e = expected_outputs.pop_front();
        if (out_elem !== e.elem) begin
          $display("%0t: out_elem expected %0d actual %0d", $time, e.elem, out_elem);
          failed = 1'b1;
        end
        if (out_index !== e.index) begin
          $display("%0t: out_index expected %0d actual %0d", $time, e.index, out_index);
          failed = 1'b1;
        end
        if (last_out !== e.last) begin
          $display("%0t: last_out expected %0b actual %0b", $time, e.last, last_out);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("gated_delta_rule_state_update_tb: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_full_head();
    test_corners();
    test_random_steps(280);
    test_output_hold_off();
    test_input_pause();
    test_random_steps(332);
    drain();
    repeat (50) @(negedge clk);
    if (!failed && expected_outputs.size() == 0)
      $display("gated_delta_rule_state_update_tb: PASS");
    else
      $display("gated_delta_rule_state_update_tb: FAIL");
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
hdl/gdr_pkg.sv
hdl/gdr_front.sv
hdl/gdr_cmd_queue.sv
hdl/gdr_back.sv
hdl/gated_delta_rule_state_update.sv
tb/gated_delta_rule_state_update_tb.sv
